// File: hw/rtl/ppmd_pkg.sv
// Package: shared types, register codes and constants of the PPM frame decoder.
`timescale 1ns / 1ps

package ppmd_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_IDX_W  = $clog2(CHANNELS);
  localparam int COUNT_W   = 4;
  localparam int VALUE_W   = 16;
  localparam int PIN_W     = 16;
  localparam int STAMP_W   = 32;
  localparam int CFG_IDX_W = 8;

  // Stick centre and the default watched pin (pin 8 mask)
  localparam logic [VALUE_W-1:0] CENTRE_VALUE       = 16'd1500;
  localparam logic [PIN_W-1:0]   WATCHED_PIN_RESET  = 16'h0100;
  localparam logic [VALUE_W-1:0] SYNC_GAP_MIN_RESET = 16'd2000;
  localparam logic [VALUE_W-1:0] PULSE_MIN_RESET    = 16'd1000;
  localparam logic [VALUE_W-1:0] PULSE_MAX_RESET    = 16'd2000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WATCHED_PIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP_MIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 8'd3;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_id;
    logic [STAMP_W-1:0] edge_time;
  } in_item_t;

  typedef struct packed {
    logic               frame_done;
    logic               synced;
    logic               short_frame_flag;
    logic [VALUE_W-1:0] left_x;
    logic [VALUE_W-1:0] left_y;
    logic [VALUE_W-1:0] right_x;
    logic [VALUE_W-1:0] right_y;
    logic [VALUE_W-1:0] switch_a;
    logic [VALUE_W-1:0] switch_b;
    logic [VALUE_W-1:0] switch_c;
    logic [VALUE_W-1:0] switch_d;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   value;
  } cfg_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   watched_pin;
    logic [VALUE_W-1:0] sync_gap_min;
    logic [VALUE_W-1:0] pulse_min;
    logic [VALUE_W-1:0] pulse_max;
  } cfg_t;

endpackage

// File: hw/rtl/ppmd_stream_if.sv
// Interface: valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps

interface ppmd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ppmd_cfg_regs.sv
// Configuration register file of the PPM frame decoder.
`timescale 1ns / 1ps

module ppmd_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  ppmd_pkg::cfg_item_t wr_item,
  output ppmd_pkg::cfg_t      cfg
);

  ppmd_pkg::cfg_t cfg_r;
  ppmd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_item.index)
        ppmd_pkg::REG_WATCHED_PIN:  cfg_nxt.watched_pin  = wr_item.value;
        ppmd_pkg::REG_SYNC_GAP_MIN: cfg_nxt.sync_gap_min = wr_item.value;
        ppmd_pkg::REG_PULSE_MIN:    cfg_nxt.pulse_min    = wr_item.value;
        ppmd_pkg::REG_PULSE_MAX:    cfg_nxt.pulse_max    = wr_item.value;
        default:                    cfg_nxt = cfg_r; // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watched_pin  <= ppmd_pkg::WATCHED_PIN_RESET;
      cfg_r.sync_gap_min <= ppmd_pkg::SYNC_GAP_MIN_RESET;
      cfg_r.pulse_min    <= ppmd_pkg::PULSE_MIN_RESET;
      cfg_r.pulse_max    <= ppmd_pkg::PULSE_MAX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/ppmd_decode.sv
// Decoder state and per-edge update: interval, sync tracking, channel capture, publish.
`timescale 1ns / 1ps

module ppmd_decode #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ppmd_pkg::in_item_t  item,
  input  ppmd_pkg::cfg_t      cfg,
  output ppmd_pkg::out_item_t result
);

  localparam int CH = ppmd_pkg::CHANNELS;
  localparam int VW = ppmd_pkg::VALUE_W;
  localparam int CW = ppmd_pkg::COUNT_W;
  localparam int IW = ppmd_pkg::CH_IDX_W;

  logic [TIME_BITS-1:0] prev_r, prev_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 flag_r, flag_nxt;
  logic [VW-1:0]        buf_r [CH];
  logic [VW-1:0]        pub_r [CH];
  logic [VW-1:0]        pub_nxt [CH];

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] delta;
  logic [CW-1:0]        count_inc;
  logic [IW-1:0]        wr_idx;
  logic                 match, gap, in_window;
  logic                 buf_we, publish;

  assign now       = TIME_BITS'(item.edge_time);
  assign delta     = now - prev_r;
  assign match     = (item.pin_id == cfg.watched_pin);
  assign gap       = (delta >= TIME_BITS'(cfg.sync_gap_min));
  assign in_window = (delta >= TIME_BITS'(cfg.pulse_min)) &&
                     (delta <= TIME_BITS'(cfg.pulse_max));
  assign count_inc = count_r + CW'(1);
  assign wr_idx    = count_r[IW-1:0];

  always_comb begin
    prev_nxt     = prev_r;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    flag_nxt     = flag_r;
    buf_we       = 1'b0;
    publish      = 1'b0;
    if (fire && match) begin
      prev_nxt = now;
      if (in_frame_r) begin
        priority if (gap) begin
          count_nxt = '0;
          flag_nxt  = 1'b1;
        end else if (in_window) begin
          buf_we    = 1'b1;
          count_nxt = count_inc;
          if (count_inc >= CW'(CH)) begin
            publish      = 1'b1;
            in_frame_nxt = 1'b0;
            count_nxt    = '0;
          end
        end else begin
          in_frame_nxt = 1'b0;
          count_nxt    = '0;
        end
      end else if (gap) begin
        in_frame_nxt = 1'b1;
        count_nxt    = '0;
        flag_nxt     = 1'b0;
      end
    end
  end

  // Published set takes the buffer with this edge's channel merged in
  always_comb begin
    for (int i = 0; i < CH; i++) begin
      if (publish) begin
        pub_nxt[i] = (IW'(i) == wr_idx) ? delta[VW-1:0] : buf_r[i];
      end else begin
        pub_nxt[i] = pub_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      in_frame_r <= 1'b0;
      count_r    <= '0;
      flag_r     <= 1'b0;
      for (int i = 0; i < CH; i++) begin
        pub_r[i] <= ppmd_pkg::CENTRE_VALUE;
      end
    end else begin
      prev_r     <= prev_nxt;
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      flag_r     <= flag_nxt;
      for (int i = 0; i < CH; i++) begin
        pub_r[i] <= pub_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[wr_idx] <= delta[VW-1:0];
    end
  end

  always_comb begin
    result.frame_done       = publish;
    result.synced           = in_frame_nxt;
    result.short_frame_flag = flag_nxt;
    result.left_x           = pub_nxt[0];
    result.left_y           = pub_nxt[1];
    result.right_x          = pub_nxt[3];
    result.right_y          = pub_nxt[2];
    result.switch_a         = pub_nxt[4];
    result.switch_b         = pub_nxt[5];
    result.switch_c         = pub_nxt[6];
    result.switch_d         = pub_nxt[7];
  end

endmodule

// File: hw/rtl/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: input register, decoder, result register.
`timescale 1ns / 1ps

// PPM frame decoder. Each input transfer is one edge event (pin mask and a
// free-running microsecond timestamp); every edge, watched or not, yields
// exactly one result transfer in order. Throughput is one edge per clock
// while the output is not stalled: the interval subtract, the threshold
// compares and the channel capture all sit between the input register and
// the result register, so each edge is held in the input register and its
// result is then registered in the result register before it is offered.
// A stalled result holds in the result register while one further edge waits
// in the input register; ready falls only when both are full. Published
// channels come up at 1500 us (stick centre) after reset with no clearing
// pass. Write configuration only while the block is idle.

module ppm_frame_decoder #(
  parameter int TIME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  ppmd_stream_if.sink   in_ch,
  ppmd_stream_if.source out_ch,
  ppmd_stream_if.sink   cfg_ch
);

  ppmd_pkg::cfg_t      cfg;
  ppmd_pkg::out_item_t result;

  // Input register stage
  logic                s1_valid_r, s1_valid_nxt;
  ppmd_pkg::in_item_t  s1_item_r;

  // Result register stage
  logic                out_valid_r, out_valid_nxt;
  ppmd_pkg::out_item_t out_item_r;

  logic in_xfer, s1_adv, fire;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  ppmd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_item (cfg_ch.data),
    .cfg     (cfg)
  );

  // Advance the input stage whenever the result register is empty or draining
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  ppmd_decode #(
    .TIME_BITS (TIME_BITS)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_ch.data;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

// File: hw/rtl/ppmd_checker.sv
// Port-level checker for the PPM frame decoder and its bind to the top level.
`timescale 1ns / 1ps

module ppmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ppmd_pkg::out_item_t out_data
);

  // No result may be offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Completing a frame always drops sync
  a_done_unsynced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.synced)
    else $error("frame completed while still synced");

endmodule

bind ppm_frame_decoder ppmd_checker u_ppmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// File: verif/tb.sv
// Self-checking testbench for the PPM frame decoder: scripted edges, then random pulse trains.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 120;
  localparam int TAIL_CYCLES = 8;

  // One line of the opening script; the expected flags are typed in only where
  // the published channels are still at stick centre
  typedef struct packed {
    logic [ppmd_pkg::PIN_W-1:0]   pin;
    logic [ppmd_pkg::STAMP_W-1:0] stamp;
    logic                         typed;
    logic                         done;
    logic                         synced;
    logic                         flag;
  } script_row_t;

  typedef struct packed {
    ppmd_pkg::in_item_t  item;
    logic                typed;
    ppmd_pkg::out_item_t want;
  } queued_edge_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Drive every channel from time zero through plain variables
  logic                src_valid  = 1'b0;
  ppmd_pkg::in_item_t  src_data   = '0;
  logic                sink_ready = 1'b0;
  logic                cfg_valid  = 1'b0;
  ppmd_pkg::cfg_item_t cfg_data   = '0;

  ppmd_stream_if #(.payload_t(ppmd_pkg::in_item_t))  in_ch ();
  ppmd_stream_if #(.payload_t(ppmd_pkg::out_item_t)) out_ch ();
  ppmd_stream_if #(.payload_t(ppmd_pkg::cfg_item_t)) cfg_ch ();

  assign in_ch.valid  = src_valid;
  assign in_ch.data   = src_data;
  assign out_ch.ready = sink_ready;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.data  = cfg_data;

  ppm_frame_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Decoder state as the testbench tracks it
  ppmd_pkg::cfg_t               cfg_now;
  logic [ppmd_pkg::STAMP_W-1:0] stamp_prev;
  logic                         locked;
  logic [ppmd_pkg::COUNT_W-1:0] slot;
  logic [ppmd_pkg::VALUE_W-1:0] capture [ppmd_pkg::CHANNELS];
  logic [ppmd_pkg::VALUE_W-1:0] shown   [ppmd_pkg::CHANNELS];
  logic                         refresh_flag;

  queued_edge_t        edge_q [$];
  ppmd_pkg::out_item_t results_due [$];

  int errors          = 0;
  int edges_accepted  = 0;
  int pins_ignored    = 0;
  int results_checked = 0;
  int frames_seen     = 0;
  int settings_used   = 0;
  int cycle_no        = 0;

  // Sender and receiver pacing
  int   burst_left    = 1;
  int   gap_left      = 0;
  logic cur_typed     = 1'b0;
  ppmd_pkg::out_item_t cur_want = '0;
  int   holds_asked   = 0;
  int   holds_granted = 0;
  int   hold_left     = 0;

  // Generator bookkeeping: timestamp of the last watched edge queued
  logic [ppmd_pkg::STAMP_W-1:0] cursor;
  int                           watched_made;

  script_row_t opening_rows [23] = '{
    // short interval before any sync: only the timestamp moves
    '{16'h0100, 32'd1500,       1'b1, 1'b0, 1'b0, 1'b0},
    // another pin: ignored
    '{16'h0200, 32'd99999,      1'b1, 1'b0, 1'b0, 1'b0},
    // interval exactly at the sync threshold enters the frame
    '{16'h0100, 32'd3500,       1'b1, 1'b0, 1'b1, 1'b0},
    // shortest legal pulse, then the longest one below the gap
    '{16'h0100, 32'd4500,       1'b1, 1'b0, 1'b1, 1'b0},
    '{16'h0100, 32'd6499,       1'b1, 1'b0, 1'b1, 1'b0},
    '{16'h0100, 32'd7499,       1'b1, 1'b0, 1'b1, 1'b0},
    // all-ones pin mask mid-frame: ignored
    '{16'hFFFF, 32'd0,          1'b1, 1'b0, 1'b1, 1'b0},
    '{16'h0100, 32'd8999,       1'b1, 1'b0, 1'b1, 1'b0},
    '{16'h0100, 32'd10299,      1'b1, 1'b0, 1'b1, 1'b0},
    '{16'h0100, 32'd11399,      1'b1, 1'b0, 1'b1, 1'b0},
    '{16'h0100, 32'd13199,      1'b1, 1'b0, 1'b1, 1'b0},
    // eighth channel publishes with the right stick swapped
    '{16'h0100, 32'd14899,      1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'd16899,      1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'd17899,      1'b0, 1'b0, 1'b0, 1'b0},
    // gap inside a frame restarts it and sets the update flag
    '{16'h0100, 32'd19899,      1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'd20899,      1'b0, 1'b0, 1'b0, 1'b0},
    // one microsecond pulse drops sync
    '{16'h0100, 32'd20900,      1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'd21899,      1'b0, 1'b0, 1'b0, 1'b0},
    // top of the timestamp range, then a gap across the wrap
    '{16'h0100, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'h0000_0FA0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'h0000_1388,  1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0100, 32'h0001_13A7,  1'b0, 1'b0, 1'b0, 1'b0},
    // zero pin mask: ignored
    '{16'h0000, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0}
  };

  // Work out the result of one edge and advance the tracked state
  function automatic ppmd_pkg::out_item_t decode_edge(ppmd_pkg::in_item_t ev);
    logic [ppmd_pkg::STAMP_W-1:0] span;
    ppmd_pkg::out_item_t          r;
    r = '0;
    if (ev.pin_id == cfg_now.watched_pin) begin
      span       = ev.edge_time - stamp_prev;
      stamp_prev = ev.edge_time;
      if (locked) begin
        if (span >= cfg_now.sync_gap_min) begin
          slot         = '0;
          refresh_flag = 1'b1;
        end else if (span >= cfg_now.pulse_min && span <= cfg_now.pulse_max) begin
          capture[slot[ppmd_pkg::CH_IDX_W-1:0]] = span[ppmd_pkg::VALUE_W-1:0];
          slot = slot + 1'b1;
          if (slot >= ppmd_pkg::CHANNELS) begin
            shown       = capture;
            locked      = 1'b0;
            slot        = '0;
            r.frame_done = 1'b1;
          end
        end else begin
          locked = 1'b0;
          slot   = '0;
        end
      end else if (span >= cfg_now.sync_gap_min) begin
        locked       = 1'b1;
        slot         = '0;
        refresh_flag = 1'b0;
      end
    end
    r.synced           = locked;
    r.short_frame_flag = refresh_flag;
    r.left_x   = shown[0];
    r.left_y   = shown[1];
    r.right_x  = shown[3];
    r.right_y  = shown[2];
    r.switch_a = shown[4];
    r.switch_b = shown[5];
    r.switch_c = shown[6];
    r.switch_d = shown[7];
    return r;
  endfunction

  // Sender: bursts of random length, random gaps, and now and then a long
  // stretch with no gaps at all
  always @(posedge clk) begin : drive_edges
    logic                loaded;
    ppmd_pkg::out_item_t predicted;
    queued_edge_t        nxt;
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      loaded = src_valid;
      if (src_valid && in_ch.ready) begin
        if (src_data.pin_id != cfg_now.watched_pin) pins_ignored++;
        predicted = decode_edge(src_data);
        results_due.push_back(cur_typed ? cur_want : predicted);
        edges_accepted++;
        loaded = 1'b0;
      end
      if (!loaded) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (edge_q.size() != 0) begin
          nxt       = edge_q.pop_front();
          src_data  <= nxt.item;
          cur_typed = nxt.typed;
          cur_want  = nxt.want;
          loaded    = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end
      // Hold valid high across back-to-back transfers with a single assignment
      src_valid <= loaded;
    end
  end

  // Receiver: its stall pattern follows bits 9:8 of the cycle count; a requested long
  // hold-off overrides it
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      sink_ready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= LONG_HOLD;
      sink_ready    <= 1'b0;
    end else begin
      case (cycle_no[9:8])
        2'd0:    sink_ready <= 1'b1;
        2'd1:    sink_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    sink_ready <= (cycle_no % 7 != 3) && (cycle_no % 5 != 0);
        default: sink_ready <= ($urandom_range(0, 9) < 4);
      endcase
    end
  end

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    ppmd_pkg::out_item_t want;
    ppmd_pkg::out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_checked++;
      if (got.frame_done === 1'b1) frames_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, got %h", $time, got);
      end else begin
        want = results_due.pop_front();
        compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        compare_field("synced", 32'(want.synced), 32'(got.synced));
        compare_field("short_frame_flag", 32'(want.short_frame_flag),
                      32'(got.short_frame_flag));
        compare_field("left_x",   32'(want.left_x),   32'(got.left_x));
        compare_field("left_y",   32'(want.left_y),   32'(got.left_y));
        compare_field("right_x",  32'(want.right_x),  32'(got.right_x));
        compare_field("right_y",  32'(want.right_y),  32'(got.right_y));
        compare_field("switch_a", 32'(want.switch_a), 32'(got.switch_a));
        compare_field("switch_b", 32'(want.switch_b), 32'(got.switch_b));
        compare_field("switch_c", 32'(want.switch_c), 32'(got.switch_c));
        compare_field("switch_d", 32'(want.switch_d), 32'(got.switch_d));
      end
    end
  end

  // Cycle count and the overall time limit
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, results_due.size());
      $display("** ppm_frame_decoder: FAILED **");
      $finish;
    end
  end

  // Wait until no edge is queued or offered and every result has arrived
  task automatic drain();
    do @(negedge clk);
    while (edge_q.size() != 0 || src_valid || results_due.size() != 0);
  endtask

  task automatic write_reg(logic [ppmd_pkg::CFG_IDX_W-1:0] idx,
                           logic [ppmd_pkg::VALUE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ppmd_pkg::cfg_item_t'{idx, val};
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    case (idx)
      ppmd_pkg::REG_WATCHED_PIN:  cfg_now.watched_pin  = val;
      ppmd_pkg::REG_SYNC_GAP_MIN: cfg_now.sync_gap_min = val;
      ppmd_pkg::REG_PULSE_MIN:    cfg_now.pulse_min    = val;
      ppmd_pkg::REG_PULSE_MAX:    cfg_now.pulse_max    = val;
      default: ;
    endcase
  endtask

  task automatic queue_edge(logic [ppmd_pkg::PIN_W-1:0] pin,
                            logic [ppmd_pkg::STAMP_W-1:0] stamp);
    queued_edge_t entry;
    entry.item  = ppmd_pkg::in_item_t'{pin, stamp};
    entry.typed = 1'b0;
    entry.want  = '0;
    edge_q.push_back(entry);
  endtask

  task automatic queue_watched(logic [ppmd_pkg::STAMP_W-1:0] delta);
    cursor = cursor + delta;
    queue_edge(cfg_now.watched_pin, cursor);
    watched_made++;
  endtask

  task automatic queue_noise();
    logic [ppmd_pkg::PIN_W-1:0] pin;
    do pin = ppmd_pkg::PIN_W'($urandom);
    while (pin == cfg_now.watched_pin);
    queue_edge(pin, $urandom);
  endtask

  // Interval that lands at or above the frame gap
  function automatic logic [ppmd_pkg::STAMP_W-1:0] gap_delta();
    case ($urandom_range(0, 7))
      0:       return ppmd_pkg::STAMP_W'(cfg_now.sync_gap_min);
      1:       return $urandom | 32'h8000_0000;
      default: return ppmd_pkg::STAMP_W'(cfg_now.sync_gap_min) + $urandom_range(0, 5000);
    endcase
  endfunction

  // Interval inside the pulse window and below the gap; a random interval
  // from 0 to 4000 when the window is empty
  function automatic logic [ppmd_pkg::STAMP_W-1:0] pulse_delta();
    int lo;
    int hi;
    lo = cfg_now.pulse_min;
    hi = cfg_now.pulse_max;
    if (hi >= int'(cfg_now.sync_gap_min)) hi = int'(cfg_now.sync_gap_min) - 1;
    if (lo > hi) return $urandom_range(0, 4000);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Mostly well-formed frames with random content; the rest truncated frames,
  // restarted frames, foreign pins and wild timestamps
  task automatic queue_sequence();
    int                           kind;
    int                           k;
    logic [ppmd_pkg::STAMP_W-1:0] bad;
    kind = $urandom_range(0, 9);
    k    = $urandom_range(0, ppmd_pkg::CHANNELS - 1);
    case (kind)
      6: begin
        queue_watched(gap_delta());
        repeat (k) queue_watched(pulse_delta());
        if (cfg_now.pulse_min != 0 && $urandom_range(0, 1) == 1)
          bad = $urandom_range(0, int'(cfg_now.pulse_min) - 1);
        else if (int'(cfg_now.pulse_max) + 1 < int'(cfg_now.sync_gap_min))
          bad = $urandom_range(int'(cfg_now.pulse_max) + 1,
                               int'(cfg_now.sync_gap_min) - 1);
        else
          bad = $urandom_range(0, 65535);
        queue_watched(bad);
      end
      7: begin
        queue_watched(gap_delta());
        repeat (k) queue_watched(pulse_delta());
        queue_watched(gap_delta());
        repeat (ppmd_pkg::CHANNELS) queue_watched(pulse_delta());
      end
      8: repeat ($urandom_range(1, 4)) queue_noise();
      9: repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 1) begin
          queue_watched($urandom);
        end else begin
          cursor = $urandom;
          queue_watched('0);
        end
      end
      default: begin
        queue_watched(gap_delta());
        repeat (ppmd_pkg::CHANNELS) begin
          if ($urandom_range(0, 9) == 0) queue_noise();
          queue_watched(pulse_delta());
        end
      end
    endcase
  endtask

  // Reprogram all registers while idle, then queue one stretch of traffic
  task automatic run_phase(ppmd_pkg::cfg_t setting, int target, bit pause_midway,
                           bit long_hold);
    drain();
    write_reg(ppmd_pkg::REG_WATCHED_PIN,  setting.watched_pin);
    write_reg(ppmd_pkg::REG_SYNC_GAP_MIN, setting.sync_gap_min);
    write_reg(ppmd_pkg::REG_PULSE_MIN,    setting.pulse_min);
    write_reg(ppmd_pkg::REG_PULSE_MAX,    setting.pulse_max);
    // A write past the last register must leave the settings alone
    write_reg(ppmd_pkg::CFG_IDX_W'($urandom_range(int'(ppmd_pkg::REG_PULSE_MAX) + 1,
                                                  (1 << ppmd_pkg::CFG_IDX_W) - 1)),
              ppmd_pkg::VALUE_W'($urandom));
    @(negedge clk);
    settings_used++;
    cursor       = stamp_prev;
    watched_made = 0;
    while (watched_made < target / 2) queue_sequence();
    if (long_hold) holds_asked++;
    if (pause_midway) drain();
    while (watched_made < target) queue_sequence();
  endtask

  initial begin : stimulus
    queued_edge_t   entry;
    ppmd_pkg::cfg_t setting;
    int             lo;
    int             hi;

    // Tracked state comes up as the block does after reset
    cfg_now      = ppmd_pkg::cfg_t'{ppmd_pkg::WATCHED_PIN_RESET,
                                    ppmd_pkg::SYNC_GAP_MIN_RESET,
                                    ppmd_pkg::PULSE_MIN_RESET,
                                    ppmd_pkg::PULSE_MAX_RESET};
    stamp_prev   = '0;
    locked       = 1'b0;
    slot         = '0;
    refresh_flag = 1'b0;
    foreach (shown[i]) begin
      shown[i]   = ppmd_pkg::CENTRE_VALUE;
      capture[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Opening script on the reset settings
    foreach (opening_rows[i]) begin
      entry.item  = ppmd_pkg::in_item_t'{opening_rows[i].pin, opening_rows[i].stamp};
      entry.typed = opening_rows[i].typed;
      entry.want  = ppmd_pkg::out_item_t'{opening_rows[i].done, opening_rows[i].synced,
                                          opening_rows[i].flag,
                                          ppmd_pkg::CENTRE_VALUE, ppmd_pkg::CENTRE_VALUE,
                                          ppmd_pkg::CENTRE_VALUE, ppmd_pkg::CENTRE_VALUE,
                                          ppmd_pkg::CENTRE_VALUE, ppmd_pkg::CENTRE_VALUE,
                                          ppmd_pkg::CENTRE_VALUE, ppmd_pkg::CENTRE_VALUE};
      edge_q.push_back(entry);
    end

    // Ordinary timing, with a long receiver hold-off to back the block up
    run_phase(ppmd_pkg::cfg_t'{16'h0100, 16'd2500, 16'd900, 16'd2100}, 320, 1'b0, 1'b1);
    // Widest window: zero-length pulses legal, gap at the top of the range
    run_phase(ppmd_pkg::cfg_t'{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}, 220, 1'b0, 1'b0);
    // Zero gap threshold: every watched edge is a frame gap
    run_phase(ppmd_pkg::cfg_t'{16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 90, 1'b0, 1'b0);
    // Empty pulse window: every non-gap interval inside a frame drops sync
    run_phase(ppmd_pkg::cfg_t'{16'h8001, 16'd3000, 16'd2000, 16'd1000}, 90, 1'b0, 1'b0);
    // Random but sensible timings; the first pauses the sender until drained
    for (int round = 0; round < 3; round++) begin
      lo      = $urandom_range(0, 3000);
      hi      = lo + $urandom_range(0, 2000);
      setting = ppmd_pkg::cfg_t'{ppmd_pkg::PIN_W'($urandom),
                                 ppmd_pkg::VALUE_W'(hi + $urandom_range(1, 3000)),
                                 ppmd_pkg::VALUE_W'(lo), ppmd_pkg::VALUE_W'(hi)};
      run_phase(setting, 140, round == 0, 1'b0);
    end
    // Back to the reset values
    run_phase(ppmd_pkg::cfg_t'{ppmd_pkg::WATCHED_PIN_RESET, ppmd_pkg::SYNC_GAP_MIN_RESET,
                               ppmd_pkg::PULSE_MIN_RESET, ppmd_pkg::PULSE_MAX_RESET},
              140, 1'b0, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
    end

    $display("Decoded %0d edges (%0d on unwatched pins) under %0d register settings,",
             edges_accepted, pins_ignored, settings_used);
    $display("checked %0d results of which %0d published a frame; %0d mismatches.",
             results_checked, frames_seen, errors);
    if (errors == 0) begin
      $display("** ppm_frame_decoder: PASSED **");
    end else begin
      $display("** ppm_frame_decoder: FAILED **");
    end
    $finish;
  end

endmodule
